/* src/prp_pkg.sv */
// Shared constants, register indexes and arithmetic helpers of the point rotate/project unit.
package prp_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int TRIG_BITS          = 16;
   localparam int CENTER_BITS        = 16;
   localparam int ZOOM_BITS          = 16;
   localparam int CSR_DATA_BITS      = 3 * CENTER_BITS;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int OUT_BITS           = 24;
   localparam int FRAC               = 14;
   localparam int PROJ_FRAC          = 8;
   localparam int REL_BITS           = 48;
   localparam int PIPE_DEPTH         = 11;
   localparam int OCC_BITS           = $clog2(PIPE_DEPTH + 1);

   localparam logic signed [TRIG_BITS-1:0] TRIG_ONE  = TRIG_BITS'(16384);
   localparam logic        [ZOOM_BITS-1:0] ZOOM_ONE  = ZOOM_BITS'(256);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COS_X  = 3'd0,
      CSR_SIN_X  = 3'd1,
      CSR_COS_Y  = 3'd2,
      CSR_SIN_Y  = 3'd3,
      CSR_COS_Z  = 3'd4,
      CSR_SIN_Z  = 3'd5,
      CSR_CENTER = 3'd6,
      CSR_ZOOM   = 3'd7
   } csr_index_type;

   // round half up: floor((v + 2^(n-1)) / 2^n)
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned n);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (n - 1));
      return t >>> n;
   endfunction

   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (OUT_BITS - 1));
      if (v > hi) begin
         return OUT_BITS'(hi);
      end else if (v < lo) begin
         return OUT_BITS'(lo);
      end else begin
         return OUT_BITS'(v);
      end
   endfunction

endpackage

/* src/prp_if.sv */
// Valid/ready channel interfaces for points in and projected results out.
interface prp_req_if #(
   parameter int COORD_BITS = prp_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] in_x;
   logic signed [COORD_BITS-1:0] in_y;
   logic signed [COORD_BITS-1:0] in_z;

   modport source (output valid, output in_x, output in_y, output in_z, input ready);
   modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface prp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [prp_pkg::OUT_BITS-1:0] screen_x;
   logic signed [prp_pkg::OUT_BITS-1:0] screen_y;
   logic signed [prp_pkg::OUT_BITS-1:0] depth;

   modport source (output valid, output screen_x, output screen_y, output depth,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input depth,
                   output ready);
endinterface

/* src/point_rotate_project_unit.sv */
// Top level of the point rotate/project unit: registers, centre offset and pipeline chain.
// Rotates each signed point about the programmed centre (X, then Y, then Z, Q1.14
// cosine/sine) and projects it with the Q8.8 zoom, giving screen x, screen y and depth
// as 24-bit saturated integers. One point is taken per clock unless back-pressure has
// filled the pipeline. Each point passes the centre subtraction register, then for each
// rotation a multiplier bank and a sum/round/clamp register, then the projection. Each
// stage holds its beat under back-pressure and empty stages close up, so a point is
// still taken while a result waits. Registers are read live; write them only while the
// pipeline is empty.
module point_rotate_project_unit #(
   parameter int COORD_BITS = prp_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [prp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [prp_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   prp_req_if.sink                               req_ch,
   prp_rsp_if.source                             rsp_ch
);

   localparam int RIN_BITS = ((COORD_BITS > prp_pkg::CENTER_BITS) ? COORD_BITS
                                                                  : prp_pkg::CENTER_BITS) + 1;
   localparam int CB = prp_pkg::CENTER_BITS;

   logic signed [prp_pkg::TRIG_BITS-1:0]   cos_x_ff, sin_x_ff;
   logic signed [prp_pkg::TRIG_BITS-1:0]   cos_y_ff, sin_y_ff;
   logic signed [prp_pkg::TRIG_BITS-1:0]   cos_z_ff, sin_z_ff;
   logic        [prp_pkg::CSR_DATA_BITS-1:0] center_ff;
   logic        [prp_pkg::ZOOM_BITS-1:0]   zoom_ff;
   logic signed [CB-1:0]                   center_x, center_y, center_z;

   logic                                   rel_v_ff, adv0;
   logic signed [RIN_BITS-1:0]             rel_x_in, rel_y_in, rel_z_in;
   logic signed [RIN_BITS-1:0]             rel_x_ff, rel_y_ff, rel_z_ff;

   logic                                   rx_ready, rx_valid;
   logic signed [prp_pkg::REL_BITS-1:0]    y1, z1, x1;
   logic                                   ry_ready, ry_valid;
   logic signed [prp_pkg::REL_BITS-1:0]    z2, x2, y2;
   logic                                   rz_ready, rz_valid;
   logic signed [prp_pkg::REL_BITS-1:0]    x3, y3, z3;
   logic                                   pj_ready;

   logic [prp_pkg::OCC_BITS-1:0]           occ_ff, occ_in;
   logic                                   req_beat, rsp_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff  <= prp_pkg::TRIG_ONE;
         sin_x_ff  <= '0;
         cos_y_ff  <= prp_pkg::TRIG_ONE;
         sin_y_ff  <= '0;
         cos_z_ff  <= prp_pkg::TRIG_ONE;
         sin_z_ff  <= '0;
         center_ff <= '0;
         zoom_ff   <= prp_pkg::ZOOM_ONE;
      end else if (csr_we) begin
         case (prp_pkg::csr_index_type'(csr_index))
            prp_pkg::CSR_COS_X:  cos_x_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_SIN_X:  sin_x_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_COS_Y:  cos_y_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_SIN_Y:  sin_y_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_COS_Z:  cos_z_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_SIN_Z:  sin_z_ff  <= csr_wdata[prp_pkg::TRIG_BITS-1:0];
            prp_pkg::CSR_CENTER: center_ff <= csr_wdata;
            prp_pkg::CSR_ZOOM:   zoom_ff   <= csr_wdata[prp_pkg::ZOOM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign center_x = center_ff[CB-1:0];
   assign center_y = center_ff[2*CB-1:CB];
   assign center_z = center_ff[3*CB-1:2*CB];

   assign adv0         = !rel_v_ff || rx_ready;
   assign req_ch.ready = adv0;

   assign rel_x_in = RIN_BITS'(req_ch.in_x) - RIN_BITS'(center_x);
   assign rel_y_in = RIN_BITS'(req_ch.in_y) - RIN_BITS'(center_y);
   assign rel_z_in = RIN_BITS'(req_ch.in_z) - RIN_BITS'(center_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_v_ff <= 1'b0;
      end else if (adv0) begin
         rel_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0 && req_ch.valid) begin
         rel_x_ff <= rel_x_in;
         rel_y_ff <= rel_y_in;
         rel_z_ff <= rel_z_in;
      end
   end

   prp_rotate #(
      .A_BITS     (RIN_BITS),
      .FRAC_SHIFT (0)
   ) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rel_v_ff),
      .in_ready  (rx_ready),
      .in_a      (rel_y_ff),
      .in_b      (rel_z_ff),
      .in_p      (prp_pkg::REL_BITS'(rel_x_ff) <<< prp_pkg::FRAC),
      .in_cos    (cos_x_ff),
      .in_sin    (sin_x_ff),
      .out_valid (rx_valid),
      .out_ready (ry_ready),
      .out_a     (y1),
      .out_b     (z1),
      .out_p     (x1)
   );

   prp_rotate #(
      .A_BITS     (prp_pkg::REL_BITS),
      .FRAC_SHIFT (prp_pkg::FRAC)
   ) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rx_valid),
      .in_ready  (ry_ready),
      .in_a      (z1),
      .in_b      (x1),
      .in_p      (y1),
      .in_cos    (cos_y_ff),
      .in_sin    (sin_y_ff),
      .out_valid (ry_valid),
      .out_ready (rz_ready),
      .out_a     (z2),
      .out_b     (x2),
      .out_p     (y2)
   );

   prp_rotate #(
      .A_BITS     (prp_pkg::REL_BITS),
      .FRAC_SHIFT (prp_pkg::FRAC)
   ) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ry_valid),
      .in_ready  (rz_ready),
      .in_a      (x2),
      .in_b      (y2),
      .in_p      (z2),
      .in_cos    (cos_z_ff),
      .in_sin    (sin_z_ff),
      .out_valid (rz_valid),
      .out_ready (pj_ready),
      .out_a     (x3),
      .out_b     (y3),
      .out_p     (z3)
   );

   prp_project u_project (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (rz_valid),
      .in_ready     (pj_ready),
      .in_x         (x3),
      .in_y         (y3),
      .in_z         (z3),
      .center_x     (center_x),
      .center_y     (center_y),
      .center_z     (center_z),
      .zoom         (zoom_ff),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_screen_x (rsp_ch.screen_x),
      .out_screen_y (rsp_ch.screen_y),
      .out_depth    (rsp_ch.depth)
   );

   assign req_beat = req_ch.valid && req_ch.ready;
   assign rsp_beat = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_beat && !rsp_beat) begin
         occ_in = occ_ff + prp_pkg::OCC_BITS'(1);
      end else if (!req_beat && rsp_beat) begin
         occ_in = occ_ff - prp_pkg::OCC_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= prp_pkg::OCC_BITS'(prp_pkg::PIPE_DEPTH))
      else $error("pipeline holds more beats than it has stages");

   a_empty_no_rsp: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> !rsp_ch.valid)
      else $error("result presented with no beat in flight");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_ch.valid || rsp_ch.ready) |-> req_ch.ready)
      else $error("input stalled although the output stage can drain");

   a_no_shortcut: assert property (@(posedge clock) disable iff (reset)
      (req_beat && occ_ff == '0) |=> !rsp_ch.valid)
      else $error("beat reached the output faster than the pipeline latency");

endmodule

/* src/prp_rotate.sv */
// Two-stage planar rotation of a coordinate pair: products, then sum, round (if FRAC_SHIFT > 0) and clamp.
module prp_rotate #(
   parameter int A_BITS     = prp_pkg::REL_BITS,
   parameter int FRAC_SHIFT = prp_pkg::FRAC
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [A_BITS-1:0]             in_a,
   input  logic signed [A_BITS-1:0]             in_b,
   input  logic signed [prp_pkg::REL_BITS-1:0]  in_p,
   input  logic signed [prp_pkg::TRIG_BITS-1:0] in_cos,
   input  logic signed [prp_pkg::TRIG_BITS-1:0] in_sin,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [prp_pkg::REL_BITS-1:0]  out_a,
   output logic signed [prp_pkg::REL_BITS-1:0]  out_b,
   output logic signed [prp_pkg::REL_BITS-1:0]  out_p
);

   localparam int PROD_BITS  = A_BITS + prp_pkg::TRIG_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int RND_BITS   = SUM_BITS - FRAC_SHIFT;
   localparam int CLAMP_BITS = (RND_BITS > prp_pkg::REL_BITS) ? RND_BITS
                                                              : prp_pkg::REL_BITS + 1;
   localparam logic signed [CLAMP_BITS-1:0] HI =
      (CLAMP_BITS'(1) <<< (prp_pkg::REL_BITS - 1)) - CLAMP_BITS'(1);
   localparam logic signed [CLAMP_BITS-1:0] LO = -HI;

   logic                                v1_ff, v2_ff;
   logic                                adv1, adv2;
   logic signed [PROD_BITS-1:0]         pac_ff, pbs_ff, pas_ff, pbc_ff;
   logic signed [prp_pkg::REL_BITS-1:0] p1_ff;
   logic signed [SUM_BITS-1:0]          na, nb;
   logic signed [RND_BITS-1:0]          ra, rb;
   logic signed [CLAMP_BITS-1:0]        ca, cb;
   logic signed [prp_pkg::REL_BITS-1:0] a_in, b_in;
   logic signed [prp_pkg::REL_BITS-1:0] a_ff, b_ff, p2_ff;

   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         pac_ff <= in_a * in_cos;
         pbs_ff <= in_b * in_sin;
         pas_ff <= in_a * in_sin;
         pbc_ff <= in_b * in_cos;
         p1_ff  <= in_p;
      end
   end

   assign na = SUM_BITS'(pac_ff) - SUM_BITS'(pbs_ff);
   assign nb = SUM_BITS'(pas_ff) + SUM_BITS'(pbc_ff);

   if (FRAC_SHIFT > 0) begin : g_round
      localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) <<< (FRAC_SHIFT - 1);
      logic signed [SUM_BITS-1:0] na_t, nb_t;
      assign na_t = na + HALF;
      assign nb_t = nb + HALF;
      assign ra   = na_t[SUM_BITS-1:FRAC_SHIFT];
      assign rb   = nb_t[SUM_BITS-1:FRAC_SHIFT];
   end else begin : g_exact
      assign ra = na;
      assign rb = nb;
   end

   assign ca = CLAMP_BITS'(ra);
   assign cb = CLAMP_BITS'(rb);

   always_comb begin
      if (ca > HI) begin
         a_in = prp_pkg::REL_BITS'(HI);
      end else if (ca < LO) begin
         a_in = prp_pkg::REL_BITS'(LO);
      end else begin
         a_in = prp_pkg::REL_BITS'(ca);
      end
      if (cb > HI) begin
         b_in = prp_pkg::REL_BITS'(HI);
      end else if (cb < LO) begin
         b_in = prp_pkg::REL_BITS'(LO);
      end else begin
         b_in = prp_pkg::REL_BITS'(cb);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         p2_ff <= p1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_p     = p2_ff;

endmodule

/* src/prp_project.sv */
// Four-stage projection: restore centre, depth sum, zoom products, round and saturate.
module prp_project (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [prp_pkg::REL_BITS-1:0]    in_x,
   input  logic signed [prp_pkg::REL_BITS-1:0]    in_y,
   input  logic signed [prp_pkg::REL_BITS-1:0]    in_z,
   input  logic signed [prp_pkg::CENTER_BITS-1:0] center_x,
   input  logic signed [prp_pkg::CENTER_BITS-1:0] center_y,
   input  logic signed [prp_pkg::CENTER_BITS-1:0] center_z,
   input  logic        [prp_pkg::ZOOM_BITS-1:0]   zoom,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [prp_pkg::OUT_BITS-1:0]    out_screen_x,
   output logic signed [prp_pkg::OUT_BITS-1:0]    out_screen_y,
   output logic signed [prp_pkg::OUT_BITS-1:0]    out_depth
);

   localparam int XA_BITS = prp_pkg::REL_BITS + 1;
   localparam int D_BITS  = XA_BITS + 2;
   localparam int SH8     = prp_pkg::FRAC - prp_pkg::PROJ_FRAC;
   localparam int X8_BITS = XA_BITS - SH8;
   localparam int D8_BITS = D_BITS - SH8;
   localparam int ZM_BITS = prp_pkg::ZOOM_BITS + 1;
   localparam int ZX_BITS = X8_BITS + ZM_BITS;
   localparam int OSH     = 2 * prp_pkg::PROJ_FRAC;

   logic                                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                                adv1, adv2, adv3, adv4;
   logic signed [XA_BITS-1:0]           xa_in, ya_in, za_in;
   logic signed [XA_BITS-1:0]           xa_ff, ya_ff, za_ff;
   logic signed [D_BITS-1:0]            d_in, d_ff;
   logic signed [X8_BITS-1:0]           x8_ff, y8_ff;
   logic signed [D8_BITS-1:0]           d8_ff;
   logic signed [ZM_BITS-1:0]           zoom_s;
   logic signed [ZX_BITS-1:0]           zx_ff, zy_ff;
   logic signed [prp_pkg::OUT_BITS-1:0] depth_ff, depth_out_ff;
   logic signed [prp_pkg::OUT_BITS-1:0] screen_x_ff, screen_y_ff;
   logic signed [63:0]                  sy_sum;

   assign adv4     = !v4_ff || out_ready;
   assign adv3     = !v3_ff || adv4;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
         if (adv4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   assign xa_in = XA_BITS'(in_x) + (XA_BITS'(center_x) <<< prp_pkg::FRAC);
   assign ya_in = XA_BITS'(in_y) + (XA_BITS'(center_y) <<< prp_pkg::FRAC);
   assign za_in = XA_BITS'(in_z) + (XA_BITS'(center_z) <<< prp_pkg::FRAC);

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         xa_ff <= xa_in;
         ya_ff <= ya_in;
         za_ff <= za_in;
      end
   end

   assign d_in = D_BITS'(xa_ff) + D_BITS'(ya_ff) + D_BITS'(za_ff);

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         d_ff  <= d_in;
         x8_ff <= X8_BITS'(prp_pkg::rnd_shift(64'(xa_ff), SH8));
         y8_ff <= X8_BITS'(prp_pkg::rnd_shift(64'(ya_ff), SH8));
      end
   end

   assign zoom_s = {1'b0, zoom};

   always_ff @(posedge clock) begin
      if (adv3 && v2_ff) begin
         zx_ff    <= x8_ff * zoom_s;
         zy_ff    <= y8_ff * zoom_s;
         d8_ff    <= D8_BITS'(prp_pkg::rnd_shift(64'(d_ff), SH8));
         depth_ff <= prp_pkg::sat_out(prp_pkg::rnd_shift(64'(d_ff), prp_pkg::FRAC));
      end
   end

   assign sy_sum = 64'(zy_ff) + (64'(d8_ff) <<< prp_pkg::PROJ_FRAC);

   always_ff @(posedge clock) begin
      if (adv4 && v3_ff) begin
         screen_x_ff  <= prp_pkg::sat_out(prp_pkg::rnd_shift(64'(zx_ff), OSH));
         screen_y_ff  <= prp_pkg::sat_out(prp_pkg::rnd_shift(sy_sum, OSH));
         depth_out_ff <= depth_ff;
      end
   end

   assign out_valid    = v4_ff;
   assign out_screen_x = screen_x_ff;
   assign out_screen_y = screen_y_ff;
   assign out_depth    = depth_out_ff;

endmodule

/* verif/tb_point_rotate_project_unit.sv */
// Self-checking testbench for the point rotate/project unit: directed and random points.
`timescale 1ns / 1ps

module tb_point_rotate_project_unit;

   localparam int COORD_BITS  = prp_pkg::COORD_BITS_DEFAULT;
   localparam int OB          = prp_pkg::OUT_BITS;
   localparam int DB          = prp_pkg::CSR_DATA_BITS;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic signed [OB-1:0] screen_x;
      logic signed [OB-1:0] screen_y;
      logic signed [OB-1:0] depth;
   } screen_point_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [prp_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [DB-1:0]                      csr_wdata;

   prp_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   prp_rsp_if                            rsp_bus ();

   point_rotate_project_unit #(.COORD_BITS(COORD_BITS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // shadow copy of the register file
   logic signed [prp_pkg::TRIG_BITS-1:0] trig_shadow [6];
   logic [3*prp_pkg::CENTER_BITS-1:0]    center_shadow;
   logic [prp_pkg::ZOOM_BITS-1:0]        zoom_shadow;

   screen_point_type projected_queue [$];
   int unsigned      fault_count = 0;
   int unsigned      lost_points;
   int unsigned      points_sent;
   int unsigned      settings_applied;
   int unsigned      quiet_cycles;
   bit               no_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint half_up_shift(input longint v, input int n);
      longint bias;
      bias = longint'(1) << (n - 1);
      return (v + bias) >>> n;
   endfunction

   function automatic logic signed [OB-1:0] clip_out(input longint v);
      if (v > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         return 24'sh800000;
      end
      return v[OB-1:0];
   endfunction

   function automatic longint clip_rel(input longint v);
      longint lim;
      lim = (longint'(1) << 47) - 1;
      if (v > lim) begin
         return lim;
      end else if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   // a' = a*c - b*s, b' = a*s + b*c, back to Q.14
   function automatic void turn_pair(inout longint a, inout longint b,
                                     input longint c, input longint s);
      longint na;
      longint nb;
      na = a * c - b * s;
      nb = a * s + b * c;
      a = clip_rel(half_up_shift(na, prp_pkg::FRAC));
      b = clip_rel(half_up_shift(nb, prp_pkg::FRAC));
   endfunction

   function automatic screen_point_type project_point(
         input logic signed [COORD_BITS-1:0] px,
         input logic signed [COORD_BITS-1:0] py,
         input logic signed [COORD_BITS-1:0] pz);
      screen_point_type res;
      longint ox, oy, oz, zm;
      longint rx, ry, rz, dsum, x8, y8, d8;
      ox = longint'($signed(center_shadow[15:0]));
      oy = longint'($signed(center_shadow[31:16]));
      oz = longint'($signed(center_shadow[47:32]));
      zm = longint'(zoom_shadow);
      rx = (longint'(px) - ox) * 16384;
      ry = (longint'(py) - oy) * 16384;
      rz = (longint'(pz) - oz) * 16384;
      turn_pair(ry, rz, longint'(trig_shadow[prp_pkg::CSR_COS_X]),
                longint'(trig_shadow[prp_pkg::CSR_SIN_X]));
      turn_pair(rz, rx, longint'(trig_shadow[prp_pkg::CSR_COS_Y]),
                longint'(trig_shadow[prp_pkg::CSR_SIN_Y]));
      turn_pair(rx, ry, longint'(trig_shadow[prp_pkg::CSR_COS_Z]),
                longint'(trig_shadow[prp_pkg::CSR_SIN_Z]));
      rx = rx + ox * 16384;
      ry = ry + oy * 16384;
      rz = rz + oz * 16384;
      dsum = rx + ry + rz;
      x8 = half_up_shift(rx, prp_pkg::FRAC - prp_pkg::PROJ_FRAC);
      y8 = half_up_shift(ry, prp_pkg::FRAC - prp_pkg::PROJ_FRAC);
      d8 = half_up_shift(dsum, prp_pkg::FRAC - prp_pkg::PROJ_FRAC);
      res.screen_x = clip_out(half_up_shift(zm * x8, 16));
      res.screen_y = clip_out(half_up_shift(zm * y8 + d8 * 256, 16));
      res.depth    = clip_out(half_up_shift(dsum, prp_pkg::FRAC));
      return res;
   endfunction

   task automatic csr_write(input prp_pkg::csr_index_type idx, input logic [DB-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      case (idx)
         prp_pkg::CSR_CENTER: center_shadow = data;
         prp_pkg::CSR_ZOOM:   zoom_shadow = data[prp_pkg::ZOOM_BITS-1:0];
         default:             trig_shadow[idx] = data[prp_pkg::TRIG_BITS-1:0];
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_rotation(input logic [15:0] cx, input logic [15:0] sx,
                               input logic [15:0] cy, input logic [15:0] sy,
                               input logic [15:0] cz, input logic [15:0] sz);
      csr_write(prp_pkg::CSR_COS_X,
                DB'({$urandom, $urandom}) & 48'hFFFF_FFFF_0000 | 48'(cx));
      csr_write(prp_pkg::CSR_SIN_X, 48'(sx));
      csr_write(prp_pkg::CSR_COS_Y, 48'(cy));
      csr_write(prp_pkg::CSR_SIN_Y, 48'(sy));
      csr_write(prp_pkg::CSR_COS_Z, 48'(cz));
      csr_write(prp_pkg::CSR_SIN_Z, 48'(sz));
      settings_applied++;
   endtask

   task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py,
                             input logic signed [COORD_BITS-1:0] pz);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 25) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.in_x  = px;
      req_bus.in_y  = py;
      req_bus.in_z  = pz;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      projected_queue.push_back(project_point(px, py, pz));
      points_sent++;
   endtask

   // drop valid and hold until every outstanding point has come back
   task automatic drain;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (projected_queue.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic signed [COORD_BITS-1:0] pick_coord;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         return COORD_BITS'($urandom);
      end else if (sel < 70) begin
         return COORD_BITS'($signed($urandom_range(0, 127)) - 64);
      end else if (sel < 85) begin
         return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      end
      return COORD_BITS'($signed($urandom_range(0, 31)) - 16 + (($urandom_range(0, 1) != 0)
                         ? 32767 : -32768));
   endfunction

   function automatic logic [15:0] pick_trig(input bit wild);
      if (wild) begin
         return 16'($urandom);
      end
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   always @(negedge clock) begin
      rsp_bus.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin : check_beat
      screen_point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (projected_queue.size() == 0) begin
            $error("result beat with no point outstanding");
            fault_count++;
         end else begin
            want = projected_queue.pop_front();
            if (rsp_bus.screen_x !== want.screen_x) begin
               $error("screen_x: expected %0d, actual %0d", want.screen_x, rsp_bus.screen_x);
               fault_count++;
            end
            if (rsp_bus.screen_y !== want.screen_y) begin
               $error("screen_y: expected %0d, actual %0d", want.screen_y, rsp_bus.screen_y);
               fault_count++;
            end
            if (rsp_bus.depth !== want.depth) begin
               $error("depth: expected %0d, actual %0d", want.depth, rsp_bus.depth);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic check_identity_extremes;
      send_point(16'sd0, 16'sd0, 16'sd0);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh7FFF, 16'sh8000, 16'sd1);
      send_point(-16'sd1, -16'sd1, -16'sd1);
      drain();
   endtask

   task automatic check_zoom_and_ties;
      csr_write(prp_pkg::CSR_ZOOM, 48'd0);
      send_point(16'sd100, -16'sd7, 16'sd3);
      send_point(16'sh8000, 16'sh7FFF, -16'sd1);
      drain();
      // half zoom puts odd coordinates on a tie
      csr_write(prp_pkg::CSR_ZOOM, 48'd128);
      csr_write(prp_pkg::CSR_COS_X, 48'd0);
      csr_write(prp_pkg::CSR_SIN_X, 48'd8192);
      send_point(16'sd1, -16'sd1, 16'sd1);
      send_point(-16'sd3, 16'sd5, -16'sd1);
      send_point(16'sd0, 16'sd0, 16'sd3);
      drain();
      settings_applied += 2;
   endtask

   task automatic check_wide_trig_saturation;
      set_rotation(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      csr_write(prp_pkg::CSR_CENTER, {16'h8000, 16'h7FFF, 16'h8000});
      csr_write(prp_pkg::CSR_ZOOM, 48'h00_0000_FFFF);
      send_point(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_point(16'sh8000, 16'sh7FFF, 16'sh8000);
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_point(16'sd0, 16'sd0, 16'sd0);
      drain();
      set_rotation(16'h7FFF, 16'h8000, 16'hC000, 16'h4000, 16'h4000, 16'hC000);
      csr_write(prp_pkg::CSR_CENTER, {16'h7FFF, 16'h8000, 16'h7FFF});
      send_point(16'sh8000, 16'sh8000, 16'sh8000);
      send_point(16'sh7FFF, 16'sh8000, 16'sh8000);
      send_point(16'sd12, -16'sd345, 16'sd6789);
      drain();
   endtask

   task automatic check_random_sweep;
      bit wild;
      for (int phase = 0; phase < 12; phase++) begin
         wild = (phase % 4 == 3);
         if (phase == 11) begin
            set_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         end else begin
            set_rotation(pick_trig(wild), pick_trig(wild), pick_trig(wild),
                         pick_trig(wild), pick_trig(wild), pick_trig(wild));
         end
         csr_write(prp_pkg::CSR_CENTER, DB'({$urandom, $urandom}));
         if (phase == 11) begin
            csr_write(prp_pkg::CSR_ZOOM, 48'hFFFF);
         end else if ($urandom_range(0, 99) < 60) begin
            csr_write(prp_pkg::CSR_ZOOM, 48'($urandom_range(0, 1023)));
         end else begin
            csr_write(prp_pkg::CSR_ZOOM, DB'({$urandom, $urandom}));
         end
         no_gaps = (phase == 2);
         for (int n = 0; n < 150; n++) begin
            if (phase == 6 && n == 75) begin
               drain();
            end
            send_point(pick_coord(), pick_coord(), pick_coord());
         end
         drain();
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.in_x     = '0;
      req_bus.in_y     = '0;
      req_bus.in_z     = '0;
      no_gaps          = 1'b0;
      lost_points      = 0;
      points_sent      = 0;
      settings_applied = 1;
      for (int i = 0; i < 6; i++) begin
         trig_shadow[i] = (i % 2 == 0) ? prp_pkg::TRIG_ONE : '0;
      end
      center_shadow = '0;
      zoom_shadow   = prp_pkg::ZOOM_ONE;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_identity_extremes();
      check_zoom_and_ties();
      check_wide_trig_saturation();
      check_random_sweep();

      drain();
      repeat (prp_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (projected_queue.size() != 0) begin
         $error("%0d points never came back", projected_queue.size());
         lost_points = projected_queue.size();
      end
      $display("Sent %0d points over %0d register settings, with back-pressure on both sides,",
               points_sent, settings_applied);
      $display("zoom of zero, rounding ties, out-of-range trig and output saturation.");
      if (fault_count == 0 && lost_points == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
src/prp_pkg.sv
src/prp_if.sv
src/prp_rotate.sv
src/prp_project.sv
src/point_rotate_project_unit.sv
verif/tb_point_rotate_project_unit.sv
